// File: hdl/bbip_pkg.sv
// Shared constants, types and helpers for the bit-plane binary inner product block.
package bbip_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int PLANES        = 8;
    localparam int WORD_BITS     = 64;
    localparam int MAX_WORDS     = MAX_DIMENSION / WORD_BITS;
    localparam int WCNT_W        = $clog2(MAX_WORDS + 1);
    localparam int PCNT_W        = $clog2(WORD_BITS + 1);
    localparam int PLANE_W       = 4;
    localparam int ADD_W         = PCNT_W + PLANES;
    localparam int PROD_W        = 21;
    localparam int ONES_W        = 13;
    localparam int IP_W          = 20;
    localparam int SCALE_W       = 32;
    localparam int SCORE_W       = 64;
    localparam int P1_W          = SCALE_W + IP_W + 1;
    localparam int P2_W          = SCALE_W + ONES_W + 1;

    localparam int IN_TDATA_W    = WORD_BITS * (PLANES + 1);
    localparam int OUT_FIELDS_W  = SCORE_W + IP_W + ONES_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] REG_PLANE_COUNT = 2'd0;
    localparam logic [1:0] REG_DELTA_SCALE = 2'd1;
    localparam logic [1:0] REG_VL_OFFSET   = 2'd2;

    localparam logic [PLANE_W-1:0] PLANE_COUNT_RST = 4'd4;
    localparam logic [SCALE_W-1:0] DELTA_SCALE_RST = 32'd65536;
    localparam logic [SCALE_W-1:0] VL_OFFSET_RST   = 32'd0;

    // One classified word, handed from the front end to the accumulator.
    typedef struct packed {
        logic [ADD_W-1:0]  add;
        logic [PCNT_W-1:0] ones;
        logic              drop;
        logic              last;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Balanced adder tree, six levels deep.
    function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_BITS-1:0] x);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++) begin
            s1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

// File: hdl/bbip_queue.sv
// Short work queue between the front end and the accumulator.
module bbip_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbip_pkg::t_work i_push_data,
    input  logic            i_pop,
    output bbip_pkg::t_work o_head,
    output bbip_pkg::t_q_stat o_stat
);
    import bbip_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: hdl/bbip_front.sv
// Front end: takes input beats, counts words, popcounts planes and builds work entries.
module bbip_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [bbip_pkg::IN_TDATA_W-1:0]   i_data,
    input  logic                              i_last,
    input  logic [bbip_pkg::PLANE_W-1:0]      i_plane_count,
    input  bbip_pkg::t_q_stat                 i_q_stat,
    output logic                              o_push,
    output bbip_pkg::t_work                   o_push_data
);
    import bbip_pkg::*;

    logic              r_valid;
    logic [WCNT_W-1:0] r_word_cnt;
    logic [PCNT_W-1:0] r_pc [PLANES];
    logic [PCNT_W-1:0] r_ones;
    logic              r_drop;
    logic              r_last;

    logic              w_take;
    logic              n_drop;
    logic [PCNT_W-1:0] n_pc [PLANES];
    logic [PCNT_W-1:0] n_ones;
    logic [ADD_W-1:0]  w_add;

    assign o_ready = !r_valid || !i_q_stat.full;
    assign w_take  = i_valid && o_ready;
    assign n_drop  = (r_word_cnt == WCNT_W'(MAX_WORDS));

    // Planes at or above the plane count, and dropped words, contribute nothing.
    always_comb begin
        n_ones = n_drop ? '0 : popcount64(i_data[WORD_BITS-1:0]);
        for (int p = 0; p < PLANES; p++) begin
            if (!n_drop && (p < int'(i_plane_count))) begin
                n_pc[p] = popcount64(i_data[WORD_BITS-1:0] &
                                     i_data[(p + 1) * WORD_BITS +: WORD_BITS]);
            end else begin
                n_pc[p] = '0;
            end
        end
    end

    always_comb begin
        w_add = '0;
        for (int p = 0; p < PLANES; p++) begin
            w_add = w_add + (ADD_W'(r_pc[p]) << p);
        end
    end

    assign o_push           = r_valid && !i_q_stat.full;
    assign o_push_data.add  = w_add;
    assign o_push_data.ones = r_ones;
    assign o_push_data.drop = r_drop;
    assign o_push_data.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_word_cnt <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_take) begin
                if (i_last) begin
                    r_word_cnt <= '0;
                end else if (!n_drop) begin
                    r_word_cnt <= r_word_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pc   <= n_pc;
            r_ones <= n_ones;
            r_drop <= n_drop;
            r_last <= i_last;
        end
    end

endmodule

// File: hdl/bbip_back.sv
// Back end: accumulates work entries, scales the totals and holds the result beat.
module bbip_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bbip_pkg::t_work                      i_head,
    input  bbip_pkg::t_q_stat                    i_q_stat,
    output logic                                 o_pop,
    input  logic [bbip_pkg::SCALE_W-1:0]         i_delta_scale,
    input  logic [bbip_pkg::SCALE_W-1:0]         i_vl_offset,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bbip_pkg::SCORE_W-1:0]         o_score,
    output logic [bbip_pkg::IP_W-1:0]            o_ip,
    output logic [bbip_pkg::ONES_W-1:0]          o_ones,
    output logic                                 o_ovf
);
    import bbip_pkg::*;

    logic [PROD_W-1:0]       r_prod;
    logic [ONES_W-1:0]       r_ones;
    logic                    r_ovf;

    logic                    r_m1_valid;
    logic [IP_W-1:0]         r_m1_ip;
    logic [ONES_W-1:0]       r_m1_ones;
    logic                    r_m1_ovf;

    logic                    r_m2_valid;
    logic signed [P1_W-1:0]  r_p1;
    logic signed [P2_W-1:0]  r_p2;
    logic [IP_W-1:0]         r_m2_ip;
    logic [ONES_W-1:0]       r_m2_ones;
    logic                    r_m2_ovf;

    logic                    r_out_valid;
    logic [SCORE_W-1:0]      r_score;
    logic [IP_W-1:0]         r_out_ip;
    logic [ONES_W-1:0]       r_out_ones;
    logic                    r_out_ovf;

    logic                    w_out_rdy;
    logic                    w_m2_rdy;
    logic                    w_m1_rdy;
    logic [PROD_W-1:0]       n_prod;
    logic [ONES_W-1:0]       n_ones;
    logic                    n_ovf;

    assign w_out_rdy = !r_out_valid || i_ready;
    assign w_m2_rdy  = !r_m2_valid || w_out_rdy;
    assign w_m1_rdy  = !r_m1_valid || w_m2_rdy;

    // Plain words always drain; a closing word waits for room in the scaling pipe.
    assign o_pop = !i_q_stat.empty && (!i_head.last || w_m1_rdy);

    assign n_prod = r_prod + PROD_W'(i_head.add);
    assign n_ones = r_ones + ONES_W'(i_head.ones);
    assign n_ovf  = r_ovf | i_head.drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod      <= '0;
            r_ones      <= '0;
            r_ovf       <= 1'b0;
            r_m1_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_head.last) begin
                    r_prod <= '0;
                    r_ones <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_prod <= n_prod;
                    r_ones <= n_ones;
                    r_ovf  <= n_ovf;
                end
            end
            if (w_m1_rdy) begin
                r_m1_valid <= o_pop && i_head.last;
            end
            if (w_m2_rdy) begin
                r_m2_valid <= r_m1_valid;
            end
            if (w_out_rdy) begin
                r_out_valid <= r_m2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_m1_ip   <= n_prod[IP_W-1:0];
            r_m1_ones <= n_ones;
            r_m1_ovf  <= n_ovf;
        end
        if (w_m2_rdy && r_m1_valid) begin
            r_p1      <= $signed(i_delta_scale) * $signed({1'b0, r_m1_ip});
            r_p2      <= $signed(i_vl_offset) * $signed({1'b0, r_m1_ones});
            r_m2_ip   <= r_m1_ip;
            r_m2_ones <= r_m1_ones;
            r_m2_ovf  <= r_m1_ovf;
        end
        if (w_out_rdy && r_m2_valid) begin
            r_score    <= SCORE_W'(r_p1) + SCORE_W'(r_p2);
            r_out_ip   <= r_m2_ip;
            r_out_ones <= r_m2_ones;
            r_out_ovf  <= r_m2_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_score = r_score;
    assign o_ip    = r_out_ip;
    assign o_ones  = r_out_ones;
    assign o_ovf   = r_out_ovf;

endmodule

// File: hdl/bitplane_binary_inner_product.sv
// Top level: register port, front end, work queue and accumulator of the bit-plane inner product.
//
// Input stream: one beat per 64-dimension word. s_axis_tdata carries the data code word
// and the eight query bit-plane words; s_axis_tlast closes a vector. Output stream: one
// beat per vector with the Q16 score, the bit inner product and the data popcount in
// m_axis_tdata and the overflow flag in m_axis_tuser.
// Throughput is one input beat per cycle while the work queue is not full, set by the popcount
// front end and the accumulate in the back end. After its closing beat is taken, the result
// beat of a vector passes the front register, queue, total register, multiply register and
// output register.
// The APB port sets plane_count, delta_scale and vl_offset; write it while no vector is
// in flight. Reset clears sums, word count, queue and all valid flags and restores the
// register defaults (4 planes, delta 1.0, offset 0).
// When the receiver stalls, the result beat holds, the scaling pipe fills, a closing word
// waits at the head of the four-entry queue while plain words ahead of it still drain,
// and s_axis_tready drops only once the queue and front register are full.
module bitplane_binary_inner_product (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // data_word, query_plane_0 .. query_plane_7 (from bit 0 up)
    input  logic [bbip_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // score, bit_inner_product, data_popcount, zero pad (from bit 0 up)
    output logic [bbip_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // overflow
    output logic                                   m_axis_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bbip_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [bbip_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [bbip_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import bbip_pkg::*;

    logic [PLANE_W-1:0] r_plane_count;
    logic [SCALE_W-1:0] r_delta_scale;
    logic [SCALE_W-1:0] r_vl_offset;

    logic               w_wr;
    logic [1:0]         w_reg_idx;
    logic               w_push;
    logic               w_pop;
    t_work              w_push_data;
    t_work              w_head;
    t_q_stat            w_q_stat;
    logic [SCORE_W-1:0] w_score;
    logic [IP_W-1:0]    w_ip;
    logic [ONES_W-1:0]  w_ones;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= PLANE_COUNT_RST;
            r_delta_scale <= DELTA_SCALE_RST;
            r_vl_offset   <= VL_OFFSET_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_PLANE_COUNT: r_plane_count <= pwdata[PLANE_W-1:0];
                REG_DELTA_SCALE: r_delta_scale <= pwdata[SCALE_W-1:0];
                REG_VL_OFFSET:   r_vl_offset   <= pwdata[SCALE_W-1:0];
                default:         r_plane_count <= r_plane_count;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_PLANE_COUNT: prdata = APB_DATA_W'(r_plane_count);
            REG_DELTA_SCALE: prdata = APB_DATA_W'(r_delta_scale);
            REG_VL_OFFSET:   prdata = APB_DATA_W'(r_vl_offset);
            default:         prdata = '0;
        endcase
    end

    bbip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_plane_count (r_plane_count),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    bbip_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    bbip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_delta_scale (r_delta_scale),
        .i_vl_offset   (r_vl_offset),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_score       (w_score),
        .o_ip          (w_ip),
        .o_ones        (w_ones),
        .o_ovf         (m_axis_tuser)
    );

    assign m_axis_tdata = {OUT_PAD_W'(0), w_ones, w_ip, w_score};

endmodule

// File: hdl/bbip_checker.sv
// Port-level checks for the bit-plane inner product top level, bound to it.
module bbip_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [bbip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                               m_axis_tuser
);
    import bbip_pkg::*;

    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_pop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[96:84] <= 13'd4096)
        else $error("data popcount beyond the dimension limit");

    a_ip_needs_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[83:64] != '0) |-> m_axis_tdata[96:84] != '0)
        else $error("nonzero inner product with empty data code");

endmodule

bind bitplane_binary_inner_product bbip_checker u_bbip_checker (.*);

// File: dv/tb_bitplane_binary_inner_product.sv
// Self-checking testbench for the bit-plane binary inner product block.
module tb_bitplane_binary_inner_product;
    timeunit 1ns;
    timeprecision 1ps;

    import bbip_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_TARGET = 450;

    typedef struct packed {
        logic [IN_TDATA_W-1:0] beat;
        logic                  last;
    } t_code_word;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [IP_W-1:0]    bip;
        logic [ONES_W-1:0]  ones;
        logic               ovf;
    } t_score;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // data_word, query_plane_0 .. query_plane_7 (from bit 0 up)
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // score, bit_inner_product, data_popcount, zero pad (from bit 0 up)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // overflow
    logic                   m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predictor copy of the registers and running sums
    logic [PLANE_W-1:0]     cfg_planes = PLANE_COUNT_RST;
    logic [SCALE_W-1:0]     cfg_delta = DELTA_SCALE_RST;
    logic [SCALE_W-1:0]     cfg_vl = VL_OFFSET_RST;
    logic [PROD_W-1:0]      prod_acc = '0;
    logic [ONES_W-1:0]      ones_acc = '0;
    logic [WCNT_W-1:0]      words_in = '0;
    logic                   words_dropped = 1'b0;

    t_code_word             pending_words[$];
    t_score                 expected_scores[$];

    logic                   in_taken = 1'b0;
    logic                   out_taken = 1'b0;
    int                     send_idle_max = 10;
    int                     recv_idle_max = 10;
    int                     tx_gap = 0;
    int                     rx_gap = 0;
    int                     hold_len = 0;
    int                     hold_token = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;
    int                     words_queued = 0;
    int                     results_seen = 0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    t_code_word             tx_word;

    bitplane_binary_inner_product i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
                 results_seen);
        mismatch_count++;
    endtask

    // Fold one accepted code word into the sums; close the vector on last.
    task automatic accumulate_word(input logic [IN_TDATA_W-1:0] beat, input logic last);
        logic [WORD_BITS-1:0] data;
        logic [PROD_W-1:0]    add;
        int                   n_planes;
        t_score               r;
        data = beat[WORD_BITS-1:0];
        n_planes = (cfg_planes > PLANES) ? PLANES : int'(cfg_planes);
        if (words_in < MAX_WORDS) begin
            add = '0;
            for (int p = 0; p < n_planes; p++)
                add = add + (PROD_W'($countones(data & beat[WORD_BITS*(p+1) +: WORD_BITS])) << p);
            prod_acc = prod_acc + add;
            ones_acc = ones_acc + ONES_W'($countones(data));
            words_in = words_in + 1'b1;
        end else begin
            words_dropped = 1'b1;
        end
        if (last) begin
            r.bip   = prod_acc[IP_W-1:0];
            r.ones  = ones_acc;
            r.ovf   = words_dropped;
            r.score = longint'($signed(cfg_delta)) * longint'(r.bip)
                    + longint'($signed(cfg_vl)) * longint'(r.ones);
            expected_scores.push_back(r);
            prod_acc      = '0;
            ones_acc      = '0;
            words_in      = '0;
            words_dropped = 1'b0;
        end
    endtask

    task automatic check_score_beat();
        t_score got;
        t_score want;
        got.score = m_axis_tdata[0 +: SCORE_W];
        got.bip   = m_axis_tdata[SCORE_W +: IP_W];
        got.ones  = m_axis_tdata[SCORE_W+IP_W +: ONES_W];
        got.ovf   = m_axis_tuser;
        results_seen++;
        if (expected_scores.size() == 0) begin
            report_mismatch("result beat with none pending", got.score, '0);
        end else begin
            want = expected_scores.pop_front();
            if (got.score !== want.score)
                report_mismatch("score", got.score, want.score);
            if (got.bip !== want.bip)
                report_mismatch("bit_inner_product", 64'(got.bip), 64'(want.bip));
            if (got.ones !== want.ones)
                report_mismatch("data_popcount", 64'(got.ones), 64'(want.ones));
            if (got.ovf !== want.ovf)
                report_mismatch("overflow", 64'(got.ovf), 64'(want.ovf));
        end
    endtask

    // Sample both streams at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_score_beat();
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            accumulate_word(s_axis_tdata, s_axis_tlast);
    end

    // Input driver: hold the beat until taken, then idle the drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                tx_word = pending_words.pop_front();
                s_axis_tdata  <= tx_word.beat;
                s_axis_tlast  <= tx_word.last;
                s_axis_tvalid <= 1'b1;
                tx_gap = $urandom_range(0, send_idle_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: per-beat stall plus an occasional long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = hold_len;
            end
            if (out_taken)
                rx_gap = $urandom_range(0, recv_idle_max);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, WORD_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [SCALE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PLANE_COUNT: cfg_planes = value[PLANE_W-1:0];
            REG_DELTA_SCALE: cfg_delta  = value;
            REG_VL_OFFSET:   cfg_vl     = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [PLANE_W-1:0] planes,
                                input logic [SCALE_W-1:0] delta,
                                input logic [SCALE_W-1:0] vl);
        reg_write(REG_PLANE_COUNT, SCALE_W'(planes));
        reg_write(REG_DELTA_SCALE, delta);
        reg_write(REG_VL_OFFSET, vl);
    endtask

    task automatic push_word(input logic [WORD_BITS-1:0] data,
                             input logic [WORD_BITS*PLANES-1:0] planes, input logic last);
        t_code_word w;
        w.beat = {planes, data};
        w.last = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_vector(input int len, input bit all_ones);
        logic [WORD_BITS*PLANES-1:0] planes;
        for (int i = 0; i < len; i++) begin
            for (int p = 0; p < PLANES; p++)
                planes[p*WORD_BITS +: WORD_BITS] = all_ones ? '1 : pick_word();
            push_word(all_ones ? '1 : pick_word(), planes, i == len - 1);
        end
    endtask

    // Wait until every word is taken and every result is back, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_scores.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: four planes, unit delta, zero offset
        push_word('1, '1, 1'b1);
        push_vector(2, 0);
        wait_drained();

        apply_config(4'd8, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word('1, '1, 1'b1);
        push_word('0, '1, 1'b1);
        push_word('1, '0, 1'b1);
        push_vector(3, 0);
        wait_drained();

        // No planes: inner product stays zero
        apply_config(4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_word('1, '1, 1'b1);
        push_vector(2, 0);
        wait_drained();

        // Plane count above the plane total saturates
        apply_config(4'd15, 32'hFFFF_FFFF, 32'h0001_0000);
        push_word('1, '1, 1'b1);
        push_vector(2, 0);
        wait_drained();

        apply_config(4'd1, 32'd0, 32'd0);
        push_vector(2, 0);
        wait_drained();

        // Full-length vector at the output extremes, then one word too many
        apply_config(4'd8, 32'h8000_0000, 32'h8000_0000);
        push_vector(MAX_WORDS, 1);
        push_vector(MAX_WORDS + 1, 0);
        wait_drained();
        apply_config(4'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vector(MAX_WORDS + 2, 1);
        wait_drained();

        // Back-pressure: hold the receiver while short vectors keep coming
        apply_config(4'($urandom_range(0, 8)), pick_scale(), pick_scale());
        send_idle_max = 0;
        recv_idle_max = 0;
        hold_len = 300;
        hold_token++;
        for (int v = 0; v < 40; v++)
            push_vector($urandom_range(1, 2), 0);
        wait_drained();

        while (words_queued < WORD_TARGET) begin
            apply_config(($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8)),
                         pick_scale(), pick_scale());
            send_idle_max = $urandom_range(0, 1) ? 10 : 0;
            recv_idle_max = $urandom_range(0, 1) ? 10 : 0;
            for (int v = 0; v < 10; v++)
                push_vector(($urandom_range(0, 39) == 0) ? $urandom_range(MAX_WORDS - 1,
                             MAX_WORDS + 2) : $urandom_range(1, 8), 0);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/bbip_pkg.sv
hdl/bbip_queue.sv
hdl/bbip_front.sv
hdl/bbip_back.sv
hdl/bitplane_binary_inner_product.sv
hdl/bbip_checker.sv
dv/tb_bitplane_binary_inner_product.sv
